[hw/rtl/pbsc_pkg.sv]
package pbsc_pkg;

   localparam int unsigned PowerWidth   = 16;
   localparam int unsigned LenWidth     = 8;
   localparam int unsigned ErrWidth     = 8;
   localparam int unsigned BalWidth     = 8;
   localparam int unsigned AntWidth     = 7;
   localparam int unsigned CadOutWidth  = 15;
   localparam int unsigned StatusWidth  = 2;

   // dividend is left*200 + total/2, fits in 24 bits
   localparam int unsigned DivWidth     = 24;
   localparam int unsigned DivCountWidth = $clog2(DivWidth);

   localparam logic [LenWidth-1:0]   MIN_RECORD_LEN = LenWidth'(11);
   localparam logic [BalWidth-1:0]   BALANCE_FULL   = BalWidth'(200);
   localparam logic [BalWidth-1:0]   BALANCE_EVEN   = BalWidth'(100);
   localparam logic [PowerWidth-1:0] POWER_RESTART  = '1;

   localparam logic [StatusWidth-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_SHORT     = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_SENSOR_ERR = 2'd2;

   typedef struct packed {
      logic                         restart;
      logic [LenWidth-1:0]          record_length;
      logic [PowerWidth-1:0]        total_watts;
      logic [PowerWidth-1:0]        left_watts;
      logic signed [PowerWidth-1:0] cadence_rpm;
      logic [PowerWidth-1:0]        crank_angle;
      logic [ErrWidth-1:0]          sensor_error;
   } req_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [PowerWidth-1:0]  power_out;
      logic [BalWidth-1:0]    balance_half_pct;
      logic [AntWidth-1:0]    ant_balance;
      logic [CadOutWidth-1:0] cadence_out;
      logic [PowerWidth-1:0]  angle_out;
   } rsp_type;

   // control from the sequencer to the clip unit
   typedef struct packed {
      logic update;
      logic restart;
      logic good;
   } clip_ctl_type;

endpackage

[hw/rtl/pbsc_div.sv]
module pbsc_div
   import pbsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DivWidth-1:0]   dividend,
   input  logic [PowerWidth-1:0] divisor,
   output logic                  done,
   output logic [DivWidth-1:0]   quotient
);

   logic [DivWidth-1:0]      quo_ff, quo_in;
   logic [PowerWidth-1:0]    rem_ff, rem_in;
   logic [PowerWidth-1:0]    div_ff, div_in;
   logic [DivCountWidth-1:0] count_ff, count_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [PowerWidth:0]      shifted;
   logic [PowerWidth+1:0]    diff;
   logic                     fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rem_ff, quo_ff[DivWidth-1]};
      diff    = {1'b0, shifted} - {2'b00, div_ff};
      fits    = !diff[PowerWidth+1];
   end

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DivWidth-2:0], fits};
         rem_in   = fits ? diff[PowerWidth-1:0] : shifted[PowerWidth-1:0];
         count_in = count_ff + DivCountWidth'(1);
         if (count_ff == DivCountWidth'(DivWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // remainder always stays below the divisor while running
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |-> rem_ff < div_ff || div_ff == '0)
      else $error("divider remainder out of range");

   assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");

endmodule

[hw/rtl/pbsc_clip.sv]
module pbsc_clip
   import pbsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [PowerWidth-1:0] csr_value,
   input  clip_ctl_type          ctl,
   input  logic [PowerWidth-1:0] total_watts,
   output logic [PowerWidth-1:0] power_out
);

   logic [PowerWidth-1:0] limit_ff, limit_in;
   logic [PowerWidth-1:0] prev_ff, prev_in;
   logic [PowerWidth-1:0] base;
   logic [PowerWidth-1:0] rise;
   logic [PowerWidth:0]   capped;
   logic                  clip;

   always_comb begin
      base   = ctl.restart ? POWER_RESTART : prev_ff;
      rise   = total_watts - base;
      capped = {1'b0, base} + {1'b0, limit_ff};
      clip   = (limit_ff != '0) && (total_watts > base) && (rise > limit_ff);
      // capped cannot pass the total here, so the low bits are exact
      power_out = clip ? capped[PowerWidth-1:0] : total_watts;
   end

   always_comb begin
      limit_in = csr_write ? csr_value : limit_ff;
      prev_in  = prev_ff;
      if (ctl.update) begin
         if (ctl.good) begin
            prev_in = power_out;
         end else if (ctl.restart) begin
            prev_in = POWER_RESTART;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
         prev_ff  <= POWER_RESTART;
      end else begin
         limit_ff <= limit_in;
         prev_ff  <= prev_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ctl.update && !ctl.good && !ctl.restart |=> $stable(prev_ff))
      else $error("rejected item changed last power");

   assert property (@(posedge clock) disable iff (reset)
      ctl.update && ctl.good && limit_ff != '0 && total_watts > base
      |-> power_out - base <= limit_ff)
      else $error("clipped rise above limit");

   assert property (@(posedge clock) disable iff (reset)
      power_out > total_watts |-> 1'b0)
      else $error("clip raised the power");

endmodule

[hw/rtl/power_balance_slew_clip_top.sv]
// power-meter record filter. one record in, one result out. a record shorter
// than 11 bytes or with a nonzero sensor error code returns only a status and
// leaves the stored last power alone (restart still resets it). a good record
// returns the total power with rising steps clipped to last power plus
// rise_limit (0 disables clipping), the left share in half percent rounded to
// nearest from the unclipped total (100 when the total is zero, clamped to
// 200), the right share percent, cadence with negatives forced to zero and the
// crank angle as is. a good record with a nonzero total goes through the
// bit-serial divider, which makes one quotient bit per cycle over 24 bits;
// other records bypass the divider and its run state. one record
// is in work at a time, but the next one is taken while a finished result
// still waits in the output register. rise_limit is written through the csr
// port at any time the block is idle; csr_ready is always high.
module power_balance_slew_clip_top
   import pbsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [PowerWidth-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // per-item work registers
   logic [StatusWidth-1:0] status_ff, status_in;
   logic [PowerWidth-1:0]  power_ff, power_in;
   logic [CadOutWidth-1:0] cad_ff, cad_in;
   logic [PowerWidth-1:0]  angle_ff, angle_in;
   logic                   zero_total_ff, zero_total_in;

   // output register
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic                  good;
   logic [StatusWidth-1:0] status_new;
   logic [DivWidth-1:0]   dividend;
   logic                  div_start;
   logic                  div_done;
   logic [DivWidth-1:0]   quotient;
   logic [PowerWidth-1:0] clip_power;
   clip_ctl_type          clip_ctl;
   logic [BalWidth-1:0]   balance;
   logic [BalWidth-1:0]   right_share;
   logic                  load_rsp;
   rsp_type               result;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // length check ranks above the sensor error
   always_comb begin
      if (req_data.record_length < MIN_RECORD_LEN) begin
         status_new = STATUS_SHORT;
      end else if (req_data.sensor_error != '0) begin
         status_new = STATUS_SENSOR_ERR;
      end else begin
         status_new = STATUS_OK;
      end
      good = (status_new == STATUS_OK);
   end

   // left*200 as shifted adds, plus total/2 for round half up
   assign dividend = {2'b00, req_data.left_watts, 6'b0}
                   + {1'b0, req_data.left_watts, 7'b0}
                   + {5'b0, req_data.left_watts, 3'b0}
                   + {9'b0, req_data.total_watts[PowerWidth-1:1]};

   assign div_start = accept && good && (req_data.total_watts != '0);

   assign clip_ctl.update  = accept;
   assign clip_ctl.restart = req_data.restart;
   assign clip_ctl.good    = good;

   pbsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (req_data.total_watts),
      .done     (div_done),
      .quotient (quotient)
   );

   pbsc_clip u_clip (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_value   (csr_data),
      .ctl         (clip_ctl),
      .total_watts (req_data.total_watts),
      .power_out   (clip_power)
   );

   // balance clamp: 100 for a zero total, anything above 200 saturates
   always_comb begin
      if (zero_total_ff) begin
         balance = BALANCE_EVEN;
      end else if (quotient[DivWidth-1:BalWidth] != '0 ||
                   quotient[BalWidth-1:0] > BALANCE_FULL) begin
         balance = BALANCE_FULL;
      end else begin
         balance = quotient[BalWidth-1:0];
      end
      right_share = BALANCE_FULL - balance;
   end

   always_comb begin
      result = '0;
      result.status = status_ff;
      if (status_ff == STATUS_OK) begin
         result.power_out        = power_ff;
         result.balance_half_pct = balance;
         result.ant_balance      = right_share[AntWidth:1];
         result.cadence_out      = cad_ff;
         result.angle_out        = angle_ff;
      end
   end

   // result moves on when the output register is empty or being drained
   assign load_rsp = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      power_in      = power_ff;
      cad_in        = cad_ff;
      angle_in      = angle_ff;
      zero_total_in = zero_total_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in     = status_new;
               power_in      = clip_power;
               cad_in        = req_data.cadence_rpm[PowerWidth-1] ?
                               '0 : req_data.cadence_rpm[CadOutWidth-1:0];
               angle_in      = req_data.crank_angle;
               zero_total_in = (req_data.total_watts == '0);
               state_in      = div_start ? ST_RUN : ST_HOLD;
            end
         end
         ST_RUN: begin
            if (div_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (load_rsp) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      power_ff      <= power_in;
      cad_ff        <= cad_in;
      angle_ff      <= angle_in;
      zero_total_ff <= zero_total_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a rejected item carries nothing but its status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_OK |->
      rsp_ff.power_out == '0 && rsp_ff.balance_half_pct == '0 &&
      rsp_ff.cadence_out == '0 && rsp_ff.angle_out == '0)
      else $error("rejected item with payload");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_OK |->
      rsp_ff.balance_half_pct <= BALANCE_FULL &&
      {1'b0, rsp_ff.ant_balance} ==
      AntWidth'((BALANCE_FULL - rsp_ff.balance_half_pct) >> 1))
      else $error("balance fields disagree");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_RUN)
      else $error("divider finished outside a run");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second item taken while one is in work");

   assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result lost on the way to the output register");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
   import pbsc_pkg::*;
();

   // cycles the block needs for its slowest record, plus margin
   localparam int unsigned SETTLE_CYCLES = 30;
   // cycles with no item moving on any port before the run is called hung
   localparam int unsigned QUIET_LIMIT   = 2000;
   // length of the long receiver hold-off
   localparam int unsigned LONG_HOLD     = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [PowerWidth-1:0] csr_data = '0;

   // predictor state: stored last power and the rise limit now in force
   logic [PowerWidth-1:0] tracked_last_power = POWER_RESTART;
   logic [PowerWidth-1:0] rise_limit_setting = '0;

   // results still owed by the block, oldest first
   rsp_type pending_results[$];

   int unsigned error_count  = 0;
   int unsigned quiet_cycles = 0;

   // random idling on both sides, switched off for the last part
   bit          idle_on      = 1'b1;
   int unsigned hold_request = 0;
   int unsigned hold_left    = 0;
   int unsigned stall_left   = 0;

   power_balance_slew_clip_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // expected result of one record; updates the tracked last power
   function automatic rsp_type predict_result(input req_type rec);
      rsp_type     res;
      logic [31:0] bal;
      logic [31:0] power;
      res = '0;
      // restart takes effect even when the record is rejected
      if (rec.restart) tracked_last_power = POWER_RESTART;
      if (rec.record_length < MIN_RECORD_LEN) begin
         // length check comes before the error code
         res.status = STATUS_SHORT;
      end else if (rec.sensor_error != '0) begin
         res.status = STATUS_SENSOR_ERR;
      end else begin
         // balance from the unclipped total, halves round up
         if (rec.total_watts == '0) begin
            bal = 32'(BALANCE_EVEN);
         end else begin
            bal = (32'(rec.left_watts) * 32'(BALANCE_FULL) + 32'(rec.total_watts) / 2)
                  / 32'(rec.total_watts);
            if (bal > 32'(BALANCE_FULL)) bal = 32'(BALANCE_FULL);
         end
         // rising step clip, a zero limit turns it off
         power = 32'(rec.total_watts);
         if (rise_limit_setting != '0 && power > 32'(tracked_last_power)) begin
            if (power - 32'(tracked_last_power) > 32'(rise_limit_setting)) begin
               power = 32'(tracked_last_power) + 32'(rise_limit_setting);
            end
         end
         tracked_last_power = power[PowerWidth-1:0];
         res.status           = STATUS_OK;
         res.power_out        = power[PowerWidth-1:0];
         res.balance_half_pct = bal[BalWidth-1:0];
         res.ant_balance      = AntWidth'((32'(BALANCE_FULL) - bal) / 2);
         res.cadence_out      = rec.cadence_rpm[PowerWidth-1] ? '0
                                : rec.cadence_rpm[CadOutWidth-1:0];
         res.angle_out        = rec.crank_angle;
      end
      return res;
   endfunction

   function automatic req_type make_record(input logic restart, input logic [7:0] len,
                                           input logic [15:0] total, input logic [15:0] left,
                                           input logic [15:0] cadence, input logic [15:0] angle,
                                           input logic [7:0] err);
      req_type rec;
      rec.restart       = restart;
      rec.record_length = len;
      rec.total_watts   = total;
      rec.left_watts    = left;
      rec.cadence_rpm   = cadence;
      rec.crank_angle   = angle;
      rec.sensor_error  = err;
      return rec;
   endfunction

   // mostly good records, totals often placed around the clip boundary
   function automatic req_type random_record();
      req_type     rec;
      int unsigned pick;
      logic [31:0] near;
      rec.restart       = ($urandom_range(0, 15) == 0);
      rec.record_length = 8'($urandom_range(32'(MIN_RECORD_LEN), 255));
      rec.sensor_error  = '0;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         rec.record_length = 8'($urandom_range(0, 32'(MIN_RECORD_LEN) - 1));
      end else if (pick == 1) begin
         rec.record_length = 8'($urandom);
         rec.sensor_error  = 8'($urandom_range(1, 255));
      end
      near = 32'(tracked_last_power) + $urandom_range(0, 2 * 32'(rise_limit_setting) + 2);
      case ($urandom_range(0, 3))
         0: rec.total_watts = 16'($urandom);
         1: rec.total_watts = 16'($urandom_range(0, 1000));
         2: rec.total_watts = (near > 32'hFFFF) ? 16'hFFFF : near[15:0];
         default: rec.total_watts = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      endcase
      case ($urandom_range(0, 2))
         0: rec.left_watts = 16'($urandom);
         1: rec.left_watts = 16'($urandom_range(0, 32'(rec.total_watts)));
         default: rec.left_watts = rec.total_watts - 16'($urandom_range(0, 3));
      endcase
      rec.cadence_rpm = 16'($urandom);
      rec.crank_angle = 16'($urandom);
      return rec;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= 200) begin
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      end
   endtask

   // offer one record, hold it until taken, then maybe go quiet for a burst
   task automatic send_record(input req_type rec);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= rec;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_result(rec));
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait for every owed result, then let the block settle
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // rise limit is only written with the block idle
   task automatic write_rise_limit(input logic [PowerWidth-1:0] value);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rise_limit_setting = value;
   endtask

   // field extremes, status priority, rounding and clip edges
   task automatic test_directed_records();
      // clipping off after reset
      send_record(make_record(1'b0, 8'd11, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0));
      send_record(make_record(1'b0, 8'd10, 16'd500, 16'd250, 16'd90, 16'd10, 8'd0));
      // short record with an error code reports short
      send_record(make_record(1'b0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_record(make_record(1'b0, 8'd255, 16'd300, 16'd100, 16'd60, 16'd45, 8'd1));
      send_record(make_record(1'b0, 8'd11, 16'd300, 16'd100, 16'd60, 16'd45, 8'h80));
      send_record(make_record(1'b0, 8'd255, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 8'd0));
      // left above total saturates
      send_record(make_record(1'b0, 8'd11, 16'd1, 16'hFFFF, 16'd0, 16'd0, 8'd0));
      // rounding: 67, exact half up, just under half
      send_record(make_record(1'b0, 8'd11, 16'd3, 16'd1, 16'd1, 16'd1, 8'd0));
      send_record(make_record(1'b0, 8'd11, 16'd400, 16'd1, 16'd1, 16'd1, 8'd0));
      send_record(make_record(1'b0, 8'd11, 16'd401, 16'd1, 16'd1, 16'd1, 8'd0));
      // most negative cadence
      send_record(make_record(1'b0, 8'd11, 16'd200, 16'd100, 16'h8000, 16'd359, 8'd0));
      // restart on a rejected record, then on a good one
      send_record(make_record(1'b1, 8'd5, 16'd1000, 16'd500, 16'd80, 16'd0, 8'd0));
      send_record(make_record(1'b1, 8'd11, 16'd1000, 16'd500, 16'd80, 16'd0, 8'd0));

      write_rise_limit(16'd100);
      send_record(make_record(1'b1, 8'd11, 16'd50, 16'd25, 16'd70, 16'd1, 8'd0));
      send_record(make_record(1'b0, 8'd11, 16'd1000, 16'd500, 16'd70, 16'd2, 8'd0));
      // no rise, rise of limit plus one, rise of exactly the limit, a drop
      send_record(make_record(1'b0, 8'd11, 16'd150, 16'd75, 16'd70, 16'd3, 8'd0));
      send_record(make_record(1'b0, 8'd11, 16'd251, 16'd100, 16'd70, 16'd4, 8'd0));
      send_record(make_record(1'b0, 8'd11, 16'd350, 16'd100, 16'd70, 16'd5, 8'd0));
      send_record(make_record(1'b0, 8'd11, 16'd10, 16'd5, 16'd70, 16'd6, 8'd0));
      // rejected record leaves the last power alone
      send_record(make_record(1'b0, 8'd11, 16'd60000, 16'd5, 16'd70, 16'd7, 8'd3));
      send_record(make_record(1'b0, 8'd11, 16'hFFFF, 16'd5, 16'd70, 16'd8, 8'd0));

      // widest limit: full-scale rise passes
      write_rise_limit(16'hFFFF);
      send_record(make_record(1'b0, 8'd11, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0));
      send_record(make_record(1'b0, 8'd11, 16'hFFFF, 16'd1, 16'd0, 16'd0, 8'd0));

      // tightest limit
      write_rise_limit(16'd1);
      send_record(make_record(1'b0, 8'd11, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0));
      send_record(make_record(1'b0, 8'd11, 16'hFFFF, 16'd1, 16'd0, 16'd0, 8'd0));
   endtask

   // random records under a spread of rise limits
   task automatic test_clip_settings();
      logic [PowerWidth-1:0] limits[5];
      limits = '{16'd0, 16'($urandom_range(1, 300)), 16'($urandom_range(1, 65535)),
                 16'hFFFF, 16'd1};
      foreach (limits[i]) begin
         write_rise_limit(limits[i]);
         repeat (130) send_record(random_record());
      end
   endtask

   // receiver holds off long enough for the input to back up, then the
   // sender stops until everything is out and then sends a second batch
   task automatic test_output_backpressure();
      write_rise_limit(16'($urandom_range(1, 500)));
      hold_request = LONG_HOLD;
      repeat (20) send_record(random_record());
      wait_until_drained();
      repeat (20) send_record(random_record());
   endtask

   // back to back with no idling on either side
   task automatic test_full_rate_stream();
      idle_on = 1'b0;
      write_rise_limit(16'($urandom_range(1, 2000)));
      repeat (100) send_record(random_record());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_records();
      test_clip_settings();
      test_output_backpressure();
      test_full_rate_stream();
      wait_until_drained();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // result ready: long hold-off on request, otherwise random stall bursts
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    <= hold_request - 1;
         hold_request <= 0;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         // start of a random stall burst
         stall_left <= $urandom_range(0, 15);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each taken result with the oldest owed one
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing owed", 64'(rsp_data), 64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.power_out !== want.power_out)
               report_mismatch("power_out", 64'(rsp_data.power_out), 64'(want.power_out));
            if (rsp_data.balance_half_pct !== want.balance_half_pct)
               report_mismatch("balance_half_pct", 64'(rsp_data.balance_half_pct),
                               64'(want.balance_half_pct));
            if (rsp_data.ant_balance !== want.ant_balance)
               report_mismatch("ant_balance", 64'(rsp_data.ant_balance),
                               64'(want.ant_balance));
            if (rsp_data.cadence_out !== want.cadence_out)
               report_mismatch("cadence_out", 64'(rsp_data.cadence_out),
                               64'(want.cadence_out));
            if (rsp_data.angle_out !== want.angle_out)
               report_mismatch("angle_out", 64'(rsp_data.angle_out), 64'(want.angle_out));
         end
      end
   end

   // hang detection: no item moving on any port for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule

[power_balance_slew_clip_top.f]
hw/rtl/pbsc_pkg.sv
hw/rtl/pbsc_div.sv
hw/rtl/pbsc_clip.sv
hw/rtl/power_balance_slew_clip_top.sv
bench/tb_top.sv
